>>> rtl/rss_pkg.sv
package rss_pkg;

    // Datapath widths
    localparam int DATA_W     = 64;
    localparam int OUT_CNT_W  = 32;
    localparam int SD_W       = 48;

    // Sample counter width and standard deviation fraction bits
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // Square root: root bits and radicand bits (value scaled by 2^(2*FRAC_BITS))
    localparam int ROOT_W     = 32 + FRAC_BITS;
    localparam int RAD_W      = 2 * ROOT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

endpackage

>>> rtl/rss_div.sv
// Restoring divider, one quotient bit per cycle.
// quotient = dividend / divisor, divisor must be non-zero.
module rss_div
    import rss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_W-1:0]     dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  done,
    output logic [DATA_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DATA_W-1:0]     quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] div_reg;

    logic [COUNT_BITS:0]   rem_shift;
    logic [COUNT_BITS:0]   rem_sub;
    logic                  fits;

    // Shift in next dividend bit, trial subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DATA_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
            rem_reg <= fits ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/rss_sqrt.sv
// Digit-by-digit integer square root of value * 2^(2*FRAC_BITS),
// one root bit per cycle, rounded down.
module rss_sqrt
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [ROOT_W+1:0] rem_shift;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    // Bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg[ROOT_W-2:0], 2'b01};
        fits      = rem_shift >= trial;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_W'(value) << (2 * FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/running_sample_statistics.sv
// Channel   Handshake                    Payload
// sample    sample_valid/sample_ready    start_time, end_time
// result    result_valid/result_ready    sample_count, mean, smallest, largest,
//                                        std_dev, count_full
//
// From one accept to the next, the sequencer runs two passes of the
// one-bit-per-cycle divider, one pass of the one-bit-per-cycle square root,
// three 32x32 multiply steps and its own sequencer steps.
// A dropped word (count full) skips the mean divide and the multiply.
// sample_ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next word is taken meanwhile.
// Reset clears the statistics to zero, the minimum to all ones.
module running_sample_statistics
    import rss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic [DATA_W-1:0]    start_time,
    input  logic [DATA_W-1:0]    end_time,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [OUT_CNT_W-1:0] sample_count,
    output logic [DATA_W-1:0]    mean,
    output logic [DATA_W-1:0]    smallest,
    output logic [DATA_W-1:0]    largest,
    output logic [SD_W-1:0]      std_dev,
    output logic                 count_full
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_D1GO  = 4'd2;
    localparam logic [3:0] ST_D1W   = 4'd3;
    localparam logic [3:0] ST_MUL0  = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_MUL2  = 4'd6;
    localparam logic [3:0] ST_SQACC = 4'd7;
    localparam logic [3:0] ST_D2GO  = 4'd8;
    localparam logic [3:0] ST_D2W   = 4'd9;
    localparam logic [3:0] ST_RTGO  = 4'd10;
    localparam logic [3:0] ST_RTW   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]            state_reg;
    logic [3:0]            state_next;

    logic [COUNT_BITS-1:0] count_reg;
    logic [DATA_W-1:0]     sum_reg;
    logic [DATA_W-1:0]     mean_reg;
    logic [DATA_W-1:0]     squares_reg;
    logic [DATA_W-1:0]     min_reg;
    logic [DATA_W-1:0]     max_reg;

    logic [DATA_W-1:0]     sample_reg;
    logic                  full_reg;
    logic [DATA_W-1:0]     a_reg;
    logic [DATA_W-1:0]     b_reg;
    logic [DATA_W-1:0]     acc_reg;

    logic                  out_valid_reg;
    logic [OUT_CNT_W-1:0]  out_count_reg;
    logic [DATA_W-1:0]     out_mean_reg;
    logic [DATA_W-1:0]     out_min_reg;
    logic [DATA_W-1:0]     out_max_reg;
    logic [SD_W-1:0]       out_sd_reg;
    logic                  out_full_reg;

    logic                  accept;
    logic                  at_max;
    logic                  out_load;

    logic [31:0]           mul_x;
    logic [31:0]           mul_y;
    logic [DATA_W-1:0]     mul_prod;

    logic                  div_start;
    logic [DATA_W-1:0]     div_dividend;
    logic                  div_done;
    logic [DATA_W-1:0]     div_quotient;

    logic                  rt_start;
    logic                  rt_done;
    logic [ROOT_W-1:0]     rt_root;
    logic [63:0]           root_wide;
    logic [SD_W-1:0]       sd_sat;
    logic [63:0]           count_wide;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign at_max       = (count_reg == COUNT_MAX);
    assign out_load     = (state_reg == ST_OUT) && (!out_valid_reg || result_ready);

    // Shared divider: mean first, then squares / count
    assign div_start    = (state_reg == ST_D1GO) || (state_reg == ST_D2GO);
    assign div_dividend = (state_reg == ST_D1GO) ? sum_reg : squares_reg;

    rss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign rt_start = (state_reg == ST_RTGO);

    rss_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_start),
        .value (div_quotient),
        .done  (rt_done),
        .root  (rt_root)
    );

    // Saturate the root to the std_dev width
    assign root_wide  = 64'(rt_root);
    assign sd_sat     = (|root_wide[63:SD_W]) ? '1 : root_wide[SD_W-1:0];
    assign count_wide = 64'(count_reg);

    // 32x32 partial products of the low 64 bits of a*b
    always_comb
    begin
        case (state_reg)
            ST_MUL1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            ST_MUL2:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
        endcase
    end

    assign mul_prod = DATA_W'(mul_x) * DATA_W'(mul_y);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = at_max ? ST_D2GO : ST_PREP;
            ST_PREP:  state_next = ST_D1GO;
            ST_D1GO:  state_next = ST_D1W;
            ST_D1W:   if (div_done) state_next = ST_MUL0;
            ST_MUL0:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_SQACC;
            ST_SQACC: state_next = ST_D2GO;
            ST_D2GO:  state_next = ST_D2W;
            ST_D2W:   if (div_done) state_next = ST_RTGO;
            ST_RTGO:  state_next = ST_RTW;
            ST_RTW:   if (rt_done) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state and running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            squares_reg   <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_PREP)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + sample_reg;
                if (min_reg > sample_reg)
                    min_reg <= sample_reg;
                if (max_reg < sample_reg)
                    max_reg <= sample_reg;
            end

            if ((state_reg == ST_D1W) && div_done)
                mean_reg <= div_quotient;

            if (state_reg == ST_SQACC)
                squares_reg <= squares_reg + acc_reg;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= end_time - start_time;
            full_reg   <= at_max;
        end

        // Old mean still in mean_reg while the new one arrives
        if ((state_reg == ST_D1W) && div_done)
        begin
            a_reg <= sample_reg - mean_reg;
            b_reg <= sample_reg - div_quotient;
        end

        case (state_reg) inside
            ST_MUL0:          acc_reg <= mul_prod;
            ST_MUL1, ST_MUL2: acc_reg <= acc_reg + {mul_prod[31:0], 32'h0};
            default:          acc_reg <= acc_reg;
        endcase

        if (out_load)
        begin
            out_count_reg <= count_wide[OUT_CNT_W-1:0];
            out_mean_reg  <= mean_reg;
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
            out_sd_reg    <= sd_sat;
            out_full_reg  <= full_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign sample_count = out_count_reg;
    assign mean         = out_mean_reg;
    assign smallest     = out_min_reg;
    assign largest      = out_max_reg;
    assign std_dev      = out_sd_reg;
    assign count_full   = out_full_reg;

    // Checks
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum after a sample");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_D1W) || (state_reg == ST_D2W)))
        else $error("divider finished outside a wait state");

    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rt_done |-> (state_reg == ST_RTW))
        else $error("square root finished outside its wait state");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (count_reg != '0))
        else $error("divide started with zero count");

    a_full_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && at_max) |=> $stable(count_reg) && $stable(sum_reg))
        else $error("dropped sample changed the statistics");

endmodule
